>>> rtl/fpap_pkg.sv
// Shared types, character codes and the per-byte scan step of the PASV address parser.
// No dependencies; used by every module of the block.
package fpap_pkg;

   localparam logic [2:0] RUN_LENGTH = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [3:0] {
      MODE_SEARCH      = 4'b0001,
      MODE_DIGITS      = 4'b0010,
      MODE_AFTER_COMMA = 4'b0100,
      MODE_AFTER_SIGN  = 4'b1000
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type mode;
      logic [2:0]    count;
      logic [31:0]   acc;
      logic          negative;
      logic          done;
   } scan_state_type;

   typedef struct packed {
      logic        en;
      logic [2:0]  index;
      logic [31:0] value;
   } store_write_type;

   typedef struct packed {
      scan_state_type  state;
      store_write_type wr;
   } feed_result_type;

   typedef struct packed {
      logic             found;
      logic [5:0][31:0] numbers;
   } scan_result_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_SEARCH, count: 3'd0, acc: 32'd0, negative: 1'b0, done: 1'b0
   };

   // One character of the scan: next state plus an optional store write.
   function automatic feed_result_type feed(scan_state_type s, logic [7:0] c);
      feed_result_type r;
      logic            digit;
      logic            space;
      logic [2:0]      next_count;
      digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      space      = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      next_count = s.count + 3'd1;
      r          = '{state: s, wr: '0};
      if (!s.done) begin
         unique case (s.mode)
            MODE_SEARCH: begin
               if (digit) begin
                  r.state.count    = 3'd0;
                  r.state.acc      = {28'd0, c[3:0]};
                  r.state.negative = 1'b0;
                  r.state.mode     = MODE_DIGITS;
               end else if (c == CHAR_NUL) begin
                  r.state.done = 1'b1;
               end
            end
            MODE_DIGITS: begin
               if (digit) begin
                  r.state.acc = (s.acc << 3) + (s.acc << 1) + {28'd0, c[3:0]};
               end else begin
                  // close the number: store it, then continue or break the run
                  r.wr.en    = (s.count < RUN_LENGTH);
                  r.wr.index = s.count;
                  r.wr.value = s.negative ? (32'd0 - s.acc) : s.acc;
                  if (next_count >= RUN_LENGTH) begin
                     r.state.count = RUN_LENGTH;
                     r.state.done  = 1'b1;
                  end else if (c == CHAR_COMMA) begin
                     r.state.count = next_count;
                     r.state.mode  = MODE_AFTER_COMMA;
                  end else begin
                     r.state.count = 3'd0;
                     r.state.mode  = MODE_SEARCH;
                     r.state.done  = (c == CHAR_NUL);
                  end
               end
            end
            MODE_AFTER_COMMA: begin
               if (space) begin
                  r.state.mode = MODE_AFTER_COMMA;
               end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                  r.state.negative = (c == CHAR_MINUS);
                  r.state.mode     = MODE_AFTER_SIGN;
               end else if (digit) begin
                  r.state.acc      = {28'd0, c[3:0]};
                  r.state.negative = 1'b0;
                  r.state.mode     = MODE_DIGITS;
               end else begin
                  r.state.count = 3'd0;
                  r.state.mode  = MODE_SEARCH;
                  r.state.done  = (c == CHAR_NUL);
               end
            end
            MODE_AFTER_SIGN: begin
               if (digit) begin
                  r.state.acc  = {28'd0, c[3:0]};
                  r.state.mode = MODE_DIGITS;
               end else begin
                  r.state.count = 3'd0;
                  r.state.mode  = MODE_SEARCH;
                  r.state.done  = (c == CHAR_NUL);
               end
            end
            default: r.state = s;
         endcase
      end
      return r;
   endfunction

   // Decimal text length of a stored number, read as signed: one for a negative value, capped at three.
   function automatic logic [1:0] text_len(logic [31:0] v);
      logic [1:0] len;
      priority if (v[31] || (v < 32'd10)) len = 2'd1;
      else if (v < 32'd100)               len = 2'd2;
      else                                len = 2'd3;
      return len;
   endfunction

endpackage

>>> rtl/fpap_scan.sv
// Byte scanner of the PASV address parser: scan state and the six-entry number store.
// Depends on fpap_pkg for the state types and the per-byte step.
module fpap_scan
   import fpap_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            end_of_line,
   output scan_result_type result
);

   scan_state_type   state_ff;
   scan_state_type   state_in;
   logic [5:0][31:0] store_ff;
   feed_result_type  first_step;
   feed_result_type  final_step;
   store_write_type  store_wr;

   always_comb begin
      first_step = feed(state_ff, data_byte);
      // end of text acts as a zero byte
      final_step = feed(first_step.state, CHAR_NUL);
      priority if (first_step.wr.en)  store_wr = first_step.wr;
      else if (end_of_line)           store_wr = final_step.wr;
      else                            store_wr = '0;
      state_in = end_of_line ? SCAN_RESET : first_step.state;
   end

   always_comb begin
      result.found = final_step.state.done && (final_step.state.count == RUN_LENGTH);
      for (int i = 0; i < 6; i++) begin
         result.numbers[i] = (store_wr.en && (store_wr.index == 3'(i))) ?
                             store_wr.value : store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_wr.en && (store_wr.index < RUN_LENGTH)) begin
         store_ff[store_wr.index] <= store_wr.value;
      end
   end

endmodule

>>> rtl/fpap_format.sv
// Result formatter of the PASV address parser: packs address, port and text lengths.
// Depends on fpap_pkg for the scan result type and text_len.
module fpap_format
   import fpap_pkg::*;
(
   input  scan_result_type result,
   output logic            found,
   output logic [31:0]     host_address,
   output logic [15:0]     port_number,
   output logic [3:0]      address_text_length,
   output logic [2:0]      port_text_length
);

   logic [3:0] addr_len;
   logic [2:0] port_len;

   always_comb begin
      addr_len = {2'd0, text_len(result.numbers[0])} + {2'd0, text_len(result.numbers[1])} +
                 {2'd0, text_len(result.numbers[2])} + {2'd0, text_len(result.numbers[3])} +
                 4'd3;
      port_len = {1'b0, text_len(result.numbers[4])} + {1'b0, text_len(result.numbers[5])} +
                 3'd1;
      found = result.found;
      if (result.found) begin
         host_address = (result.numbers[3] << 24) | (result.numbers[2] << 16) |
                        (result.numbers[1] << 8) | result.numbers[0];
         port_number         = {result.numbers[4][7:0], result.numbers[5][7:0]};
         address_text_length = addr_len;
         port_text_length    = port_len;
      end else begin
         host_address        = 32'd0;
         port_number         = 16'd0;
         address_text_length = 4'd0;
         port_text_length    = 3'd0;
      end
   end

endmodule

>>> rtl/ftp_passive_address_parser_top.sv
// Latency: the result of a reply appears in the cycle after its end-of-line byte is taken.
// Throughput: one byte per cycle; the scan step and formatting sit between the scan
// registers and a single result register. A request waits while a result is held
// unread; draining the result frees the input in the same cycle.
// Reset: synchronous, active high; clears the scan state and the result valid flag.
// Depends on fpap_pkg, fpap_scan and fpap_format.
module ftp_passive_address_parser_top
   import fpap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_host_address,
   output logic [15:0] rsp_port_number,
   output logic [3:0]  rsp_address_text_length,
   output logic [2:0]  rsp_port_text_length
);

   scan_result_type scan_result;
   logic            accept;
   logic            load;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            found_in;
   logic [31:0]     ip_in;
   logic [15:0]     port_in;
   logic [3:0]      alen_in;
   logic [2:0]      plen_in;
   logic            found_ff;
   logic [31:0]     ip_ff;
   logic [15:0]     port_ff;
   logic [3:0]      alen_ff;
   logic [2:0]      plen_ff;

   // take a request whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign load      = accept && req_end_of_line;

   fpap_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_line (req_end_of_line),
      .result      (scan_result)
   );

   fpap_format u_format (
      .result              (scan_result),
      .found               (found_in),
      .host_address        (ip_in),
      .port_number         (port_in),
      .address_text_length (alen_in),
      .port_text_length    (plen_in)
   );

   always_comb begin
      priority if (load)   rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         found_ff <= found_in;
         ip_ff    <= ip_in;
         port_ff  <= port_in;
         alen_ff  <= alen_in;
         plen_ff  <= plen_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_found               = found_ff;
   assign rsp_host_address        = ip_ff;
   assign rsp_port_number         = port_ff;
   assign rsp_address_text_length = alen_ff;
   assign rsp_port_text_length    = plen_ff;

`ifndef SYNTHESIS
   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("end-of-line request did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while a stalled result waits");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> ((rsp_host_address == 32'd0)
         && (rsp_port_number == 16'd0)
         && (rsp_address_text_length == 4'd0) && (rsp_port_text_length == 3'd0)))
      else $error("result fields not cleared for a reply without an address");

   a_found_lengths: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> ((rsp_address_text_length >= 4'd7)
         && (rsp_port_text_length >= 3'd3)))
      else $error("text lengths too short for a found address");
`endif

endmodule
